// ----- rtl/cdlb_pkg.sv -----
`timescale 1ns / 1ps

package cdlb_pkg;

    localparam int NUM_CHUNKS       = 16;
    localparam int CHUNK_BYTES      = 64;
    localparam int CHECKPOINT_BYTES = 8;

    localparam int CHUNK_W = $clog2(NUM_CHUNKS);
    localparam int OFS_W   = $clog2(CHUNK_BYTES);
    localparam int ADDR_W  = CHUNK_W + OFS_W;
    localparam int USED_W  = $clog2(NUM_CHUNKS + 1);
    localparam int DEPTH   = NUM_CHUNKS * CHUNK_BYTES;

    localparam logic [1:0] REQ_CKPT   = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_NOT_FULL   = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd3;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd4;

    typedef struct packed {
        logic [2:0]         status;
        logic [CHUNK_W-1:0] chunk_index;
        logic [OFS_W-1:0]   offset;
        logic [7:0]         data_byte;
        logic               data_valid;
        logic               last;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_port_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_port_t;

endpackage

// ----- rtl/cdlb_store.sv -----
`timescale 1ns / 1ps

module cdlb_store
(
    input  logic                 clk,
    input  cdlb_pkg::wr_port_t   wr,
    input  cdlb_pkg::rd_port_t   rd,
    output logic [7:0]           rdata
);

    logic [7:0] mem [cdlb_pkg::DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cdlb_seq.sv -----
`timescale 1ns / 1ps

module cdlb_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [63:0]         checkpoint_data,
    input  logic [7:0]          row_id,
    input  logic [7:0]          patch_index,
    input  logic [15:0]         offset_end,
    input  logic [15:0]         dest_size,
    input  logic                slot_free,
    output logic                push,
    output cdlb_pkg::result_t   res,
    output cdlb_pkg::wr_port_t  wr,
    output cdlb_pkg::rd_port_t  rd,
    input  logic [7:0]          rdata
);

    localparam int CHUNK_W = cdlb_pkg::CHUNK_W;
    localparam int OFS_W   = cdlb_pkg::OFS_W;
    localparam int USED_W  = cdlb_pkg::USED_W;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_CKPT,
        S_RD_ISSUE,
        S_RD_DATA,
        S_RESULT
    } state_t;

    state_t               state_reg, state_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [CHUNK_W-1:0]   active_reg, active_next;
    logic [OFS_W-1:0]     wofs_reg, wofs_next;
    logic [63:0]          cp_reg, cp_next;
    logic [CHUNK_W-1:0]   idx_reg, idx_next;
    logic [OFS_W-1:0]     n_reg, n_next;
    logic [OFS_W-1:0]     k_reg, k_next;
    cdlb_pkg::result_t    res_reg, res_next;

    logic                 full;
    logic                 roll;
    logic [CHUNK_W-1:0]   wa_chunk;
    logic [OFS_W-1:0]     wa_ofs;
    logic [15:0]          n_full;
    logic                 byte_ok;
    logic                 rd_last;
    cdlb_pkg::result_t    rd_res;

    function automatic cdlb_pkg::result_t status_only(input logic [2:0] st);
        cdlb_pkg::result_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    assign full     = int'(used_reg) >= cdlb_pkg::NUM_CHUNKS;
    assign roll     = wofs_reg >= OFS_W'(cdlb_pkg::CHUNK_BYTES - 1);
    assign wa_chunk = roll ? used_reg[CHUNK_W-1:0] : active_reg;
    assign wa_ofs   = roll ? '0 : wofs_reg;
    assign n_full   = (offset_end < dest_size) ? offset_end : dest_size;

    // bytes past the fill point of a chunk were never written and read as zero
    assign byte_ok = (idx_reg < active_reg) || ((idx_reg == active_reg) && (k_reg < wofs_reg));
    assign rd_last = (k_reg == n_reg - OFS_W'(1));

    always_comb
    begin
        rd_res            = '0;
        rd_res.status     = cdlb_pkg::ST_OK;
        rd_res.data_byte  = byte_ok ? rdata : 8'd0;
        rd_res.data_valid = 1'b1;
        rd_res.last       = rd_last;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign push     = slot_free && ((state_reg == S_RESULT) || (state_reg == S_RD_DATA));
    assign res      = (state_reg == S_RD_DATA) ? rd_res : res_reg;
    assign rd.en    = (state_reg == S_RD_ISSUE);
    assign rd.addr  = {idx_reg, k_reg};

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        active_next = active_reg;
        wofs_next   = wofs_reg;
        cp_next     = cp_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        res_next    = res_reg;
        wr          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        cdlb_pkg::REQ_CKPT:
                        begin
                            cp_next = checkpoint_data;
                            k_next  = '0;
                            if (wofs_reg == '0)
                            begin
                                state_next = S_CKPT;
                            end
                            else if (full)
                            begin
                                res_next   = status_only(cdlb_pkg::ST_NO_SPACE);
                                state_next = S_RESULT;
                            end
                            else if (wofs_reg != OFS_W'(cdlb_pkg::CHUNK_BYTES - 1))
                            begin
                                res_next   = status_only(cdlb_pkg::ST_NOT_FULL);
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                active_next = used_reg[CHUNK_W-1:0];
                                used_next   = used_reg + USED_W'(1);
                                state_next  = S_CKPT;
                            end
                        end
                        cdlb_pkg::REQ_APPEND:
                        begin
                            if (roll && full)
                            begin
                                res_next = status_only(cdlb_pkg::ST_NO_SPACE);
                            end
                            else
                            begin
                                wr.en                = 1'b1;
                                wr.addr              = {wa_chunk, wa_ofs};
                                wr.data              = row_id;
                                active_next          = wa_chunk;
                                used_next            = roll ? used_reg + USED_W'(1) : used_reg;
                                wofs_next            = wa_ofs + OFS_W'(1);
                                res_next             = '0;
                                res_next.status      = cdlb_pkg::ST_OK;
                                res_next.chunk_index = wa_chunk;
                                res_next.offset      = wa_ofs + OFS_W'(1);
                                res_next.last        = 1'b1;
                            end
                            state_next = S_RESULT;
                        end
                        cdlb_pkg::REQ_READ:
                        begin
                            idx_next = patch_index[CHUNK_W-1:0];
                            n_next   = n_full[OFS_W-1:0];
                            k_next   = '0;
                            if (int'(patch_index) >= cdlb_pkg::NUM_CHUNKS)
                            begin
                                res_next   = status_only(cdlb_pkg::ST_BAD_INDEX);
                                state_next = S_RESULT;
                            end
                            else if (int'(offset_end) >= cdlb_pkg::CHUNK_BYTES)
                            begin
                                res_next   = status_only(cdlb_pkg::ST_BAD_OFFSET);
                                state_next = S_RESULT;
                            end
                            else if (n_full == 16'd0)
                            begin
                                res_next   = status_only(cdlb_pkg::ST_OK);
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_RD_ISSUE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CKPT:
            begin
                wr.en   = 1'b1;
                wr.addr = {active_reg, k_reg};
                wr.data = cp_reg[7:0];
                cp_next = cp_reg >> 8;
                k_next  = k_reg + OFS_W'(1);
                if (k_reg == OFS_W'(cdlb_pkg::CHECKPOINT_BYTES - 1))
                begin
                    wofs_next            = OFS_W'(cdlb_pkg::CHECKPOINT_BYTES);
                    res_next             = '0;
                    res_next.status      = cdlb_pkg::ST_OK;
                    res_next.chunk_index = active_reg;
                    res_next.offset      = OFS_W'(cdlb_pkg::CHECKPOINT_BYTES);
                    res_next.last        = 1'b1;
                    state_next           = S_RESULT;
                end
            end
            S_RD_ISSUE:
            begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (slot_free)
                begin
                    if (rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + OFS_W'(1);
                        state_next = S_RD_ISSUE;
                    end
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= USED_W'(1);
            active_reg <= '0;
            wofs_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            active_reg <= active_next;
            wofs_reg   <= wofs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg  <= cp_next;
        idx_reg <= idx_next;
        n_reg   <= n_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    // chunks are opened in order, so the active chunk is always the newest one
    a_active_newest: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == ({1'b0, active_reg} + USED_W'(1)))
        else $error("active chunk is not the last opened chunk");

    a_used_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> used_reg >= $past(used_reg))
        else $error("chunk count went down");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> ((state_reg == S_IDLE) || (state_reg == S_CKPT)))
        else $error("store written outside append or checkpoint");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_DATA) |-> (k_reg < n_reg))
        else $error("read position past requested length");

endmodule

// ----- rtl/chunked_delete_log_buffer.sv -----
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// in       | in_valid / in_ready    | req_type checkpoint_data row_id patch_index
//          |                        | offset_end dest_size
// out      | out_valid / out_ready  | status chunk_index offset data_byte data_valid
//          |                        | last
//
// an append or any error goes from idle straight to the result; a checkpoint first writes its
// CHECKPOINT_BYTES bytes, one store write per cycle through the single write port
// a read handles each byte in two steps: address issue, then registered store data
// no clearing pass after reset: bytes past the fill point of each chunk read as zero
// the block takes no new transaction until the current one's last result is in
// the output register; a full output register holds the sequencer in place

module chunked_delete_log_buffer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [63:0] checkpoint_data,
    input  logic [7:0]  row_id,
    input  logic [7:0]  patch_index,
    input  logic [15:0] offset_end,
    input  logic [15:0] dest_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  chunk_index,
    output logic [5:0]  offset,
    output logic [7:0]  data_byte,
    output logic        data_valid,
    output logic        last
);

    cdlb_pkg::wr_port_t wr;
    cdlb_pkg::rd_port_t rd;
    cdlb_pkg::result_t  res;
    cdlb_pkg::result_t  out_reg;
    logic [7:0]         rdata;
    logic               push;
    logic               slot_free;
    logic               out_valid_reg;

    assign slot_free = !out_valid_reg || out_ready;

    cdlb_store u_store
    (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    cdlb_seq u_seq
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .checkpoint_data (checkpoint_data),
        .row_id          (row_id),
        .patch_index     (patch_index),
        .offset_end      (offset_end),
        .dest_size       (dest_size),
        .slot_free       (slot_free),
        .push            (push),
        .res             (res),
        .wr              (wr),
        .rd              (rd),
        .rdata           (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign chunk_index = out_reg.chunk_index;
    assign offset      = out_reg.offset;
    assign data_byte   = out_reg.data_byte;
    assign data_valid  = out_reg.data_valid;
    assign last        = out_reg.last;

endmodule

// ----- verif/tb_chunked_delete_log_buffer.sv -----
`timescale 1ns / 1ps

module tb_chunked_delete_log_buffer;

    localparam int CHUNK_W = cdlb_pkg::CHUNK_W;
    localparam int OFS_W   = cdlb_pkg::OFS_W;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 150;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [63:0] checkpoint_data = '0;
    logic [7:0]  row_id = '0;
    logic [7:0]  patch_index = '0;
    logic [15:0] offset_end = '0;
    logic [15:0] dest_size = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [3:0]  chunk_index;
    logic [5:0]  offset;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last;

    // mirror of the log contents and write pointer
    logic [7:0] mirror_log [cdlb_pkg::DEPTH];
    int         mirror_used;
    int         mirror_chunk;
    int         mirror_ofs;

    cdlb_pkg::result_t pending_results [$];
    bit         src_idle_en = 1'b0;
    bit         sink_idle_en = 1'b0;
    int         sink_hold = 0;
    int         quiet_cycles = 0;
    int         err_count = 0;
    int         n_sent = 0;
    int         n_ckpt = 0;
    int         n_append = 0;
    int         n_read = 0;
    int         n_checked = 0;
    int         status_hits [5] = '{default: 0};

    chunked_delete_log_buffer i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .checkpoint_data (checkpoint_data),
        .row_id          (row_id),
        .patch_index     (patch_index),
        .offset_end      (offset_end),
        .dest_size       (dest_size),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .chunk_index     (chunk_index),
        .offset          (offset),
        .data_byte       (data_byte),
        .data_valid      (data_valid),
        .last            (last)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    function automatic void open_fresh_chunk();
        mirror_chunk = mirror_used;
        mirror_used++;
        mirror_ofs = 0;
        for (int k = 0; k < cdlb_pkg::CHUNK_BYTES; k++)
        begin
            mirror_log[mirror_chunk * cdlb_pkg::CHUNK_BYTES + k] = 8'h00;
        end
    endfunction

    function automatic void predict_log_request(input logic [1:0] rt, input logic [63:0] ckpt,
                                                input logic [7:0] row, input logic [7:0] pidx,
                                                input logic [15:0] oend, input logic [15:0] dsz);
        cdlb_pkg::result_t r;
        int      nbytes;
        r = '0;
        r.last = 1'b1;
        case (rt)
            cdlb_pkg::REQ_CKPT:
            begin
                if (mirror_ofs != 0 && mirror_used >= cdlb_pkg::NUM_CHUNKS)
                    r.status = cdlb_pkg::ST_NO_SPACE;
                else if (mirror_ofs != 0 && mirror_ofs != cdlb_pkg::CHUNK_BYTES - 1)
                    r.status = cdlb_pkg::ST_NOT_FULL;
                else
                begin
                    if (mirror_ofs != 0)
                        open_fresh_chunk();
                    for (int k = 0; k < cdlb_pkg::CHECKPOINT_BYTES; k++)
                    begin
                        mirror_log[mirror_chunk * cdlb_pkg::CHUNK_BYTES + k] = ckpt[8 * k +: 8];
                    end
                    mirror_ofs = cdlb_pkg::CHECKPOINT_BYTES;
                    r.status = cdlb_pkg::ST_OK;
                    r.chunk_index = CHUNK_W'(mirror_chunk);
                    r.offset = OFS_W'(mirror_ofs);
                end
                status_hits[r.status]++;
                pending_results.push_back(r);
            end
            cdlb_pkg::REQ_APPEND:
            begin
                if (mirror_ofs >= cdlb_pkg::CHUNK_BYTES - 1 &&
                    mirror_used >= cdlb_pkg::NUM_CHUNKS)
                    r.status = cdlb_pkg::ST_NO_SPACE;
                else
                begin
                    if (mirror_ofs >= cdlb_pkg::CHUNK_BYTES - 1)
                        open_fresh_chunk();
                    mirror_log[mirror_chunk * cdlb_pkg::CHUNK_BYTES + mirror_ofs] = row;
                    mirror_ofs++;
                    r.status = cdlb_pkg::ST_OK;
                    r.chunk_index = CHUNK_W'(mirror_chunk);
                    r.offset = OFS_W'(mirror_ofs);
                end
                status_hits[r.status]++;
                pending_results.push_back(r);
            end
            cdlb_pkg::REQ_READ:
            begin
                nbytes = (oend < dsz) ? int'(oend) : int'(dsz);
                if (pidx >= cdlb_pkg::NUM_CHUNKS)
                    r.status = cdlb_pkg::ST_BAD_INDEX;
                else if (oend >= cdlb_pkg::CHUNK_BYTES)
                    r.status = cdlb_pkg::ST_BAD_OFFSET;
                else
                    r.status = cdlb_pkg::ST_OK;
                status_hits[r.status]++;
                if (r.status != cdlb_pkg::ST_OK || nbytes == 0)
                    pending_results.push_back(r);
                else
                begin
                    for (int k = 0; k < nbytes; k++)
                    begin
                        r.data_byte = mirror_log[int'(pidx) * cdlb_pkg::CHUNK_BYTES + k];
                        r.data_valid = 1'b1;
                        r.last = (k == nbytes - 1);
                        pending_results.push_back(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_request(input logic [1:0] rt, input logic [63:0] ckpt,
                                input logic [7:0] row, input logic [7:0] pidx,
                                input logic [15:0] oend, input logic [15:0] dsz);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clk);
        end
        @(negedge clk);
        req_type        <= rt;
        checkpoint_data <= ckpt;
        row_id          <= row;
        patch_index     <= pidx;
        offset_end      <= oend;
        dest_size       <= dsz;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_log_request(rt, ckpt, row, pidx, oend, dsz);
        case (rt)
            cdlb_pkg::REQ_CKPT:   n_ckpt++;
            cdlb_pkg::REQ_APPEND: n_append++;
            cdlb_pkg::REQ_READ:   n_read++;
            default:    ;
        endcase
        if (rt != REQ_NONE)
            n_sent++;
    endtask

    task automatic do_checkpoint(input logic [63:0] ckpt);
        send_request(cdlb_pkg::REQ_CKPT, ckpt, 8'($urandom), 8'($urandom), 16'($urandom),
                     16'($urandom));
    endtask

    task automatic do_append(input logic [7:0] row);
        send_request(cdlb_pkg::REQ_APPEND, {$urandom, $urandom}, row, 8'($urandom),
                     16'($urandom), 16'($urandom));
    endtask

    task automatic do_read(input logic [7:0] pidx, input logic [15:0] oend,
                           input logic [15:0] dsz);
        send_request(cdlb_pkg::REQ_READ, {$urandom, $urandom}, 8'($urandom), pidx, oend, dsz);
    endtask

    task automatic do_noise();
        send_request(REQ_NONE, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom));
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        do_read(8'd0, 16'd0, 16'd5);
        do_read(8'd0, 16'd10, 16'd0);
        do_checkpoint(64'hFFFF_FFFF_FFFF_FFFF);
        do_read(8'd0, 16'(cdlb_pkg::CHUNK_BYTES - 1), 16'hFFFF);
        do_read(8'hFF, 16'hFFFF, 16'hFFFF);
        do_read(8'(cdlb_pkg::NUM_CHUNKS), 16'd5, 16'd5);
        do_read(8'd0, 16'(cdlb_pkg::CHUNK_BYTES), 16'd5);
        do_read(8'(cdlb_pkg::NUM_CHUNKS - 1), 16'hFFFF, 16'd0);
        do_checkpoint(64'h0123_4567_89AB_CDEF);
        do_append(8'h00);
        do_noise();
        do_append(8'hFF);
        do_read(8'd0, 16'd12, 16'd3);
        do_read(8'd0, 16'd11, 16'd40);
        do_read(8'(cdlb_pkg::NUM_CHUNKS - 1), 16'(cdlb_pkg::CHUNK_BYTES - 1), 16'hFFFF);
    endtask

    // fill to the chunk edge: not_full just before it, then a checkpoint and an append roll
    task automatic test_chunk_rollover();
        while (mirror_ofs < cdlb_pkg::CHUNK_BYTES - 2)
            do_append(8'($urandom));
        do_checkpoint({$urandom, $urandom});
        do_append(8'($urandom));
        do_checkpoint({$urandom, $urandom});
        while (mirror_ofs < cdlb_pkg::CHUNK_BYTES - 1)
            do_append(8'($urandom));
        do_append(8'($urandom));
        do_read(8'(mirror_chunk - 1), 16'(cdlb_pkg::CHUNK_BYTES - 1), 16'hFFFF);
    endtask

    task automatic test_random_mix();
        int start;
        int pick;
        logic [7:0]  pidx;
        logic [15:0] oend;
        logic [15:0] dsz;
        start = n_sent;
        while (n_sent - start < RANDOM_ITEMS)
        begin
            src_idle_en = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                repeat ($urandom_range(1, 20)) do_append(8'($urandom));
            end
            else if (pick < 55)
            begin
                if (mirror_ofs >= 40 && mirror_used < cdlb_pkg::NUM_CHUNKS - 2)
                begin
                    while (mirror_ofs < cdlb_pkg::CHUNK_BYTES - 1)
                        do_append(8'($urandom));
                    if ($urandom_range(0, 1) == 0)
                        do_checkpoint({$urandom, $urandom});
                    else
                        do_append(8'($urandom));
                end
                else
                    do_checkpoint({$urandom, $urandom});
            end
            else if (pick < 80)
            begin
                pick = $urandom_range(0, 9);
                pidx = (pick < 8) ? 8'($urandom_range(0, cdlb_pkg::NUM_CHUNKS - 1))
                                  : 8'($urandom_range(cdlb_pkg::NUM_CHUNKS, 255));
                oend = ($urandom_range(0, 4) != 0)
                       ? 16'($urandom_range(0, cdlb_pkg::CHUNK_BYTES - 1))
                       : 16'($urandom_range(cdlb_pkg::CHUNK_BYTES, 65535));
                pick = $urandom_range(0, 4);
                if (pick < 2)
                    dsz = 16'($urandom_range(0, cdlb_pkg::CHUNK_BYTES));
                else if (pick < 4)
                    dsz = 16'($urandom_range(32768, 65535));
                else
                    dsz = 16'($urandom);
                do_read(pidx, oend, dsz);
            end
            else if (pick < 93)
                do_checkpoint({$urandom, $urandom});
            else
                do_noise();
        end
    endtask

    task automatic test_log_exhaustion();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        while (mirror_used < cdlb_pkg::NUM_CHUNKS)
            do_append(8'($urandom));
        // no free chunk is reported ahead of a partly filled chunk
        do_checkpoint({$urandom, $urandom});
        while (mirror_ofs < cdlb_pkg::CHUNK_BYTES - 1)
            do_append(8'($urandom));
        do_checkpoint({$urandom, $urandom});
        do_append(8'($urandom));
        for (int c = 0; c < cdlb_pkg::NUM_CHUNKS; c++)
            do_read(8'(c), 16'(cdlb_pkg::CHUNK_BYTES - 1), 16'hFFFF);
    endtask

    always @(negedge clk)
    begin
        if (sink_hold > 0)
            sink_hold--;
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            sink_hold = $urandom_range(0, 9);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cdlb_pkg::result_t got;
        cdlb_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, chunk_index, offset, data_byte, data_valid, last};
            if (pending_results.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result: status=%0d chunk=%0d ofs=%0d byte=%02h %s",
                             got.status, got.chunk_index, got.offset, got.data_byte,
                             $sformatf("dv=%0b last=%0b", got.data_valid, got.last));
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.status !== want.status || got.chunk_index !== want.chunk_index ||
                    got.offset !== want.offset || got.data_byte !== want.data_byte ||
                    got.data_valid !== want.data_valid || got.last !== want.last)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("mismatch exp: status=%0d chunk=%0d ofs=%0d byte=%02h %s",
                                 want.status, want.chunk_index, want.offset, want.data_byte,
                                 $sformatf("dv=%0b last=%0b", want.data_valid, want.last));
                        $display("         got: status=%0d chunk=%0d ofs=%0d byte=%02h %s",
                                 got.status, got.chunk_index, got.offset, got.data_byte,
                                 $sformatf("dv=%0b last=%0b", got.data_valid, got.last));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transaction in %0d cycles", QUIET_LIMIT);
            $display("tb_chunked_delete_log_buffer: FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < cdlb_pkg::DEPTH; i++)
            mirror_log[i] = 8'h00;
        mirror_used = 1;
        mirror_chunk = 0;
        mirror_ofs = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        wait_for_drain();
        test_chunk_rollover();
        test_random_mix();
        wait_for_drain();
        test_log_exhaustion();
        wait_for_drain();

        if (pending_results.size() != 0)
            err_count++;
        $display("covered %0d requests (%0d checkpoints, %0d appends, %0d reads), %0d checked",
                 n_sent, n_ckpt, n_append, n_read, n_checked);
        $display("all %0d chunks filled; no_space %0d, not_full %0d, bad index %0d, %s",
                 cdlb_pkg::NUM_CHUNKS, status_hits[cdlb_pkg::ST_NO_SPACE],
                 status_hits[cdlb_pkg::ST_NOT_FULL], status_hits[cdlb_pkg::ST_BAD_INDEX],
                 $sformatf("bad offset %0d", status_hits[cdlb_pkg::ST_BAD_OFFSET]));
        if (err_count == 0)
            $display("tb_chunked_delete_log_buffer: PASS");
        else
            $display("tb_chunked_delete_log_buffer: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cdlb_pkg.sv
rtl/cdlb_store.sv
rtl/cdlb_seq.sv
rtl/chunked_delete_log_buffer.sv
verif/tb_chunked_delete_log_buffer.sv
